### hdl/sigrrip_pkg.sv
// ----------------------------------------------------------------------------
// sigrrip_pkg
// Sizes, row layout and controller/datapath interface types for the
// signature-based RRIP replacement unit.
// ----------------------------------------------------------------------------
package sigrrip_pkg;

    localparam int SETS            = 2048;
    localparam int WAYS            = 16;
    localparam int RRPV_WIDTH      = 2;
    localparam int SIGNATURE_WIDTH = 15;
    localparam int COUNTER_MAX     = 7;

    // port field widths
    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int PC_W     = 64;
    localparam int RR_OUT_W = 2;
    localparam int THR_W    = 3;
    localparam logic [THR_W-1:0] THR_RESET = 3'd3;

    localparam int SET_W       = $clog2(SETS);
    localparam int WAY_W       = $clog2(WAYS);
    localparam int SIG_W       = SIGNATURE_WIDTH;
    localparam int SIG_ENTRIES = 1 << SIGNATURE_WIDTH;
    localparam int CNT_W       = $clog2(COUNTER_MAX + 1);
    localparam int CMP_W       = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int RRPV_LEVELS = 1 << RRPV_WIDTH;

    localparam logic [RRPV_WIDTH-1:0] RRPV_TOP  = {RRPV_WIDTH{1'b1}};
    localparam logic [RRPV_WIDTH-1:0] RRPV_NEAR = RRPV_TOP - 1'b1;
    localparam logic [RRPV_WIDTH-1:0] RRPV_HIT  = '0;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(COUNTER_MAX);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(COUNTER_MAX >> 1);

    // clearing pass covers the larger of the two stores
    localparam int CLR_DEPTH = (SIG_ENTRIES > SETS) ? SIG_ENTRIES : SETS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // one set row: every way's state side by side
    typedef struct packed {
        logic [WAYS-1:0][SIG_W-1:0]      sig;
        logic [WAYS-1:0]                 reused;
        logic [WAYS-1:0][RRPV_WIDTH-1:0] rrpv;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    localparam row_t ROW_INIT = '{sig: '0, reused: '0, rrpv: {WAYS{RRPV_TOP}}};

    // controller -> datapath
    typedef struct packed {
        logic clear;   // clearing pass, one entry per cycle
        logic load;    // word accepted: latch fields, issue reads
        logic eval;    // row and counter data valid
        logic old_rd;  // read counter of evicted signature
        logic fill;    // update counters, write row, issue result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic is_hit;
    } sts_t;

endpackage

### hdl/sigrrip_ram.sv
// ----------------------------------------------------------------------------
// sigrrip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sigrrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sigrrip_ctrl.sv
// ----------------------------------------------------------------------------
// sigrrip_ctrl
// Sequencer: clearing pass after reset, then a hit sequence (eval) or a miss
// sequence (eval, old_rd, fill) per accepted word.
// ----------------------------------------------------------------------------
module sigrrip_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sigrrip_pkg::sts_t sts,
    output sigrrip_pkg::cmd_t cmd
);
    import sigrrip_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_OLDRD = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = sts.is_hit ? S_IDLE : S_OLDRD;
            end
            S_OLDRD:
            begin
                state_next = S_FILL;
            end
            S_FILL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign cmd.clear  = (state_reg == S_CLEAR);
    assign cmd.load   = (state_reg == S_IDLE) && start;
    assign cmd.eval   = (state_reg == S_EVAL);
    assign cmd.old_rd = (state_reg == S_OLDRD);
    assign cmd.fill   = (state_reg == S_FILL);

endmodule

### hdl/sigrrip_dp.sv
// ----------------------------------------------------------------------------
// sigrrip_dp
// Datapath: set-row and signature-counter stores, victim search, ageing,
// counter training, insertion decision and result register.
// ----------------------------------------------------------------------------
module sigrrip_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sigrrip_pkg::cmd_t                   cmd,
    output sigrrip_pkg::sts_t                   sts,
    input  logic [sigrrip_pkg::SET_IN_W-1:0]    set_index,
    input  logic [sigrrip_pkg::WAY_IN_W-1:0]    hit_way,
    input  logic [sigrrip_pkg::PC_W-1:0]        pc,
    input  logic                                hit,
    input  logic                                cfg_valid,
    input  logic [sigrrip_pkg::THR_W-1:0]       cfg_data,
    output logic                                done,
    output logic [sigrrip_pkg::WAY_IN_W-1:0]    chosen_way,
    output logic [sigrrip_pkg::RR_OUT_W-1:0]    new_rrpv
);
    import sigrrip_pkg::*;

    // control registers
    logic [CLR_W-1:0] clr_cnt_reg;
    logic [THR_W-1:0] thr_reg;
    logic             done_reg;

    // payload registers
    logic [SET_W-1:0]      set_reg;
    logic [WAY_W-1:0]      way_reg;
    logic [SIG_W-1:0]      sig_reg;
    logic                  hit_reg;
    row_t                  row_reg;
    logic [WAY_W-1:0]      victim_reg;
    logic [CNT_W-1:0]      csig_reg;
    logic [WAY_W-1:0]      chosen_reg;
    logic [RRPV_WIDTH-1:0] rr_reg;

    // RAM ports
    logic                   row_we;
    logic [SET_W-1:0]       row_waddr;
    row_t                   row_wdata;
    logic [ROW_W-1:0]       row_rbits;
    row_t                   row_rd;
    logic                   ctr_we;
    logic [SIG_W-1:0]       ctr_waddr;
    logic [CNT_W-1:0]       ctr_wdata;
    logic [SIG_W-1:0]       ctr_raddr;
    logic [CNT_W-1:0]       ctr_rdata;

    // combinational
    logic [SIG_W-1:0]       sig_in;
    logic [RRPV_LEVELS-1:0] any_lvl;
    logic [RRPV_WIDTH-1:0]  top;
    logic [RRPV_WIDTH-1:0]  gap;
    logic [WAY_W-1:0]       victim;
    row_t                   aged;
    row_t                   hit_row;
    row_t                   fill_row;
    logic [SIG_W-1:0]       old_sig;
    logic                   dec;
    logic [CNT_W-1:0]       old_dec;
    logic [CNT_W-1:0]       new_cnt;
    logic [RRPV_WIDTH-1:0]  fill_rr;
    logic [CNT_W-1:0]       hit_cnt;

    assign sig_in = pc[SIG_W-1:0] ^ pc[2*SIG_W-1:SIG_W];
    assign row_rd = row_t'(row_rbits);

    sigrrip_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (set_index[SET_W-1:0]),
        .rdata (row_rbits)
    );

    sigrrip_ram #(.WIDTH(CNT_W), .DEPTH(SIG_ENTRIES)) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    // victim search: highest level present, then first way at it
    always_comb
    begin
        any_lvl = '0;
        for (int v = 0; v < RRPV_LEVELS; v++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (row_rd.rrpv[w] == RRPV_WIDTH'(v))
                begin
                    any_lvl[v] = 1'b1;
                end
            end
        end
        top = '0;
        for (int v = 0; v < RRPV_LEVELS; v++)
        begin
            if (any_lvl[v])
            begin
                top = RRPV_WIDTH'(v);
            end
        end
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_rd.rrpv[w] == top)
            begin
                victim = WAY_W'(w);
            end
        end
        gap  = RRPV_TOP - top;
        aged = row_rd;
        for (int w = 0; w < WAYS; w++)
        begin
            aged.rrpv[w] = row_rd.rrpv[w] + gap;
        end
    end

    // hit update
    always_comb
    begin
        hit_row                 = row_rd;
        hit_row.rrpv[way_reg]   = RRPV_HIT;
        hit_row.reused[way_reg] = 1'b1;
        hit_cnt = (ctr_rdata < CNT_MAX) ? ctr_rdata + 1'b1 : ctr_rdata;
    end

    // miss fill: train evicted signature down, decide insertion
    assign old_sig = row_reg.sig[victim_reg];
    assign dec     = !row_reg.reused[victim_reg] && (ctr_rdata != '0);
    assign old_dec = ctr_rdata - 1'b1;
    // new signature may be the evicted one: take the decremented count
    assign new_cnt = (dec && (old_sig == sig_reg)) ? old_dec : csig_reg;
    assign fill_rr = (CMP_W'(new_cnt) > CMP_W'(thr_reg)) ? RRPV_NEAR : RRPV_TOP;

    always_comb
    begin
        fill_row                    = row_reg;
        fill_row.rrpv[victim_reg]   = fill_rr;
        fill_row.sig[victim_reg]    = sig_reg;
        fill_row.reused[victim_reg] = 1'b0;
    end

    // store write muxing
    always_comb
    begin
        row_we    = 1'b0;
        row_waddr = set_reg;
        row_wdata = fill_row;
        ctr_we    = 1'b0;
        ctr_waddr = sig_reg;
        ctr_wdata = hit_cnt;
        ctr_raddr = cmd.old_rd ? old_sig : sig_in;
        if (cmd.clear)
        begin
            row_we    = (32'(clr_cnt_reg) < SETS);
            row_waddr = clr_cnt_reg[SET_W-1:0];
            row_wdata = ROW_INIT;
            ctr_we    = (32'(clr_cnt_reg) < SIG_ENTRIES);
            ctr_waddr = clr_cnt_reg[SIG_W-1:0];
            ctr_wdata = CNT_INIT;
        end
        else if (cmd.eval && hit_reg)
        begin
            row_we    = 1'b1;
            row_wdata = hit_row;
            ctr_we    = 1'b1;
        end
        else if (cmd.fill)
        begin
            row_we    = 1'b1;
            ctr_we    = dec;
            ctr_waddr = old_sig;
            ctr_wdata = old_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            thr_reg     <= THR_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            done_reg <= (cmd.eval && hit_reg) || cmd.fill;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg <= set_index[SET_W-1:0];
            way_reg <= hit_way[WAY_W-1:0];
            sig_reg <= sig_in;
            hit_reg <= hit;
        end
        if (cmd.eval)
        begin
            row_reg    <= aged;
            victim_reg <= victim;
            csig_reg   <= ctr_rdata;
            if (hit_reg)
            begin
                chosen_reg <= way_reg;
                rr_reg     <= RRPV_HIT;
            end
        end
        if (cmd.fill)
        begin
            chosen_reg <= victim_reg;
            rr_reg     <= fill_rr;
        end
    end

    assign sts.clear_done = (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1));
    assign sts.is_hit     = hit_reg;
    assign done           = done_reg;
    assign chosen_way     = WAY_IN_W'(chosen_reg);
    assign new_rrpv       = RR_OUT_W'(rr_reg);

endmodule

### hdl/signature_rrip_replacement_unit.sv
// ----------------------------------------------------------------------------
// signature_rrip_replacement_unit
// Signature-based RRIP replacement: per-set re-reference values, line
// signatures and reuse flags, with a shared table of signature counters.
// ----------------------------------------------------------------------------
// Sequence: a hit's result is registered in eval, a miss's in fill after
//   eval and old_rd. Start is taken only in idle, once the last word is
//   through: the set row is read-modify-written, a miss reads two counters.
// Reset: a clearing pass initialises both stores; busy is high meanwhile.
//   The threshold register is writable throughout.
// Results cannot be stalled: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module signature_rrip_replacement_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // access word
    input  logic                                start,
    output logic                                busy,
    input  logic [sigrrip_pkg::SET_IN_W-1:0]    set_index,
    input  logic [sigrrip_pkg::WAY_IN_W-1:0]    hit_way,
    input  logic [sigrrip_pkg::PC_W-1:0]        pc,
    input  logic                                hit,
    // result word
    output logic                                done,
    output logic [sigrrip_pkg::WAY_IN_W-1:0]    chosen_way,
    output logic [sigrrip_pkg::RR_OUT_W-1:0]    new_rrpv,
    // threshold register write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sigrrip_pkg::THR_W-1:0]       cfg_data
);
    import sigrrip_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // threshold write always taken
    assign cfg_ready = 1'b1;

    // sequencer: clear pass, then per-word hit or miss sequence
    sigrrip_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // stores, victim search, counter training, result register
    sigrrip_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .set_index  (set_index),
        .hit_way    (hit_way),
        .pc         (pc),
        .hit        (hit),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .done       (done),
        .chosen_way (chosen_way),
        .new_rrpv   (new_rrpv)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signature-based RRIP replacement unit. Access
// words go in through the start/busy handshake with random gaps. Every
// result word is checked against a behavioural replacement model that is
// updated as each access word is accepted.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sigrrip_pkg::*;

    localparam int          LINES        = SETS * WAYS;
    localparam int unsigned CYCLE_LIMIT  = 600000;  // clearing pass plus slow traffic, many times over
    localparam int          PHASE_WORDS  = 213;     // random words per threshold setting
    localparam int          HOT_SETS     = 8;
    localparam int          HOT_PCS      = 12;

    // one result word as the block reports it
    typedef struct packed {
        logic [WAY_IN_W-1:0] way;
        logic [RR_OUT_W-1:0] rrpv;
    } fill_result_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   start      = 1'b0;
    logic                   busy;
    logic [SET_IN_W-1:0]    set_index  = '0;
    logic [WAY_IN_W-1:0]    hit_way    = '0;
    logic [PC_W-1:0]        pc         = '0;
    logic                   hit        = 1'b0;
    logic                   done;
    logic [WAY_IN_W-1:0]    chosen_way;
    logic [RR_OUT_W-1:0]    new_rrpv;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [THR_W-1:0]       cfg_data   = '0;

    // ------------------------------------------------------------------------
    // Replacement model state, mirrors the block's stores
    // ------------------------------------------------------------------------
    logic [RRPV_WIDTH-1:0]  line_rrpv   [LINES];
    logic [SIG_W-1:0]       line_sig    [LINES];
    logic                   line_reused [LINES];
    logic [CNT_W-1:0]       sig_count   [SIG_ENTRIES];
    logic [THR_W-1:0]       reuse_thr;

    fill_result_t           expected_fills [$];

    bit                     idle_enable   = 1'b1;
    int unsigned            fail_count    = 0;
    int unsigned            checked_words = 0;
    int unsigned            hit_words     = 0;
    int unsigned            miss_words    = 0;
    int unsigned            near_fills    = 0;
    int unsigned            cycle_count   = 0;

    signature_rrip_replacement_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .set_index  (set_index),
        .hit_way    (hit_way),
        .pc         (pc),
        .hit        (hit),
        .done       (done),
        .chosen_way (chosen_way),
        .new_rrpv   (new_rrpv),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model: one accepted access word -> the fill it causes.
    // Hit: promote to 0, mark reused, train signature up (saturating).
    // Miss: age set until a way is distant, take the first such way, train the
    // evicted signature down if never reused, insert near/distant by counter.
    // ------------------------------------------------------------------------
    function automatic fill_result_t predict_fill(
        input logic [SET_IN_W-1:0] set_in,
        input logic [WAY_IN_W-1:0] way_in,
        input logic [PC_W-1:0]     pc_in,
        input logic                hit_in
    );
        int unsigned           base;
        int unsigned           way;
        int                    w;
        logic [SIG_W-1:0]      sig;
        logic [SIG_W-1:0]      old_sig;
        logic [RRPV_WIDTH-1:0] top;
        logic [RRPV_WIDTH-1:0] gap;
        fill_result_t          res;

        base = (int'(set_in) % SETS) * WAYS;
        sig  = SIG_W'(pc_in ^ (pc_in >> SIG_W));
        if (hit_in)
        begin
            way = int'(way_in) % WAYS;
            line_rrpv[base + way]   = RRPV_HIT;
            line_reused[base + way] = 1'b1;
            if (sig_count[sig] < CNT_MAX)
                sig_count[sig] = sig_count[sig] + 1'b1;
            res.rrpv = RR_OUT_W'(RRPV_HIT);
        end
        else
        begin
            // strict compare keeps the lowest way at the largest value
            top = '0;
            way = 0;
            for (w = 0; w < WAYS; w++)
            begin
                if (line_rrpv[base + w] > top)
                begin
                    top = line_rrpv[base + w];
                    way = w;
                end
            end
            gap = RRPV_TOP - top;
            for (w = 0; w < WAYS; w++)
                line_rrpv[base + w] = line_rrpv[base + w] + gap;
            old_sig = line_sig[base + way];
            if (!line_reused[base + way] && sig_count[old_sig] != '0)
                sig_count[old_sig] = sig_count[old_sig] - 1'b1;
            line_sig[base + way]    = sig;
            line_reused[base + way] = 1'b0;
            if (CMP_W'(sig_count[sig]) > CMP_W'(reuse_thr))
                line_rrpv[base + way] = RRPV_NEAR;
            else
                line_rrpv[base + way] = RRPV_TOP;
            res.rrpv = RR_OUT_W'(line_rrpv[base + way]);
        end
        res.way = WAY_IN_W'(way);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Send one access word. A zero gap keeps start high into the next word,
    // so start is never dropped and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_access(
        input logic [SET_IN_W-1:0] set_in,
        input logic [WAY_IN_W-1:0] way_in,
        input logic [PC_W-1:0]     pc_in,
        input logic                hit_in
    );
        int           gap;
        fill_result_t res;

        gap = idle_enable ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        set_index <= set_in;
        hit_way   <= way_in;
        pc        <= pc_in;
        hit       <= hit_in;
        // values read here are the pre-edge ones: accepted when busy was low
        do
            @(posedge clk);
        while (busy);
        res = predict_fill(set_in, way_in, pc_in, hit_in);
        expected_fills.push_back(res);
        if (hit_in)
            hit_words++;
        else
            miss_words++;
        if (!hit_in && res.rrpv == RR_OUT_W'(RRPV_NEAR))
            near_fills++;
    endtask

    // Let every outstanding result arrive, then a few quiet cycles
    task automatic wait_for_fills();
        start <= 1'b0;
        while (expected_fills.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Threshold write; only called with the block idle
    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        reuse_thr = value;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: done is a single-cycle strobe, sampled at the edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        fill_result_t exp_fill;
        if (rst_n && done)
        begin
            if (expected_fills.size() == 0)
            begin
                $error("result word with nothing outstanding: chosen_way %0d new_rrpv %0d",
                       chosen_way, new_rrpv);
                fail_count++;
            end
            else
            begin
                exp_fill = expected_fills.pop_front();
                checked_words++;
                if (chosen_way !== exp_fill.way)
                begin
                    $error("chosen_way: expected %0d, actual %0d", exp_fill.way, chosen_way);
                    fail_count++;
                end
                if (new_rrpv !== exp_fill.rrpv)
                begin
                    $error("new_rrpv: expected %0d, actual %0d", exp_fill.rrpv, new_rrpv);
                    fail_count++;
                end
            end
        end
    end

    // Cycle counter guards against a hung handshake
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner values of every field at the reset threshold; includes a hit on
    // a line that was never filled.
    task automatic test_field_extremes();
        send_access('0, '0, '0, 1'b0);
        send_access('1, '0, '1, 1'b0);
        send_access('1, '1, '1, 1'b1);
        send_access(SET_IN_W'(9), '0, 64'h5555_aaaa_5555_aaaa, 1'b1);
        wait_for_fills();
    endtask

    // Hit every way of one set so all lines sit at 0, then miss: the whole
    // set must age by the full gap and way 0 is taken.
    task automatic test_set_ageing();
        int w;
        for (w = 0; w < WAYS; w++)
            send_access(SET_IN_W'(100), WAY_IN_W'(w), 64'h0000_0040_0000_1230, 1'b1);
        send_access(SET_IN_W'(100), '0, 64'h0000_0000_0000_7777, 1'b0);
        wait_for_fills();
    endtask

    // Lowest threshold inserts near for an untrained signature, highest never
    task automatic test_threshold_extremes();
        write_threshold('0);
        send_access(SET_IN_W'(1), '0, 64'h1234_5678_9abc_def0, 1'b0);
        wait_for_fills();
        write_threshold('1);
        send_access(SET_IN_W'(1), '0, 64'h0fed_cba9_8765_4321, 1'b0);
        send_access(SET_IN_W'(1), WAY_IN_W'(1), 64'h0fed_cba9_8765_4321, 1'b1);
        wait_for_fills();
    endtask

    // One threshold setting of random traffic. Most words hit a few hot sets
    // with a few hot PCs so counters train both ways and sets age; the rest
    // are fully random words. Idle gaps switch on and off in stretches.
    task automatic run_traffic_phase(input logic [THR_W-1:0] thr);
        logic [SET_IN_W-1:0] hot_set [HOT_SETS];
        logic [PC_W-1:0]     hot_pc  [HOT_PCS];
        logic [SET_IN_W-1:0] s;
        logic [PC_W-1:0]     p;
        int                  n;

        write_threshold(thr);
        for (n = 0; n < HOT_SETS; n++)
            hot_set[n] = SET_IN_W'($urandom);
        for (n = 0; n < HOT_PCS; n++)
            hot_pc[n] = {$urandom, $urandom};
        for (n = 0; n < PHASE_WORDS; n++)
        begin
            if (n % 60 == 0)
                idle_enable = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) != 0)
            begin
                s = hot_set[$urandom_range(0, HOT_SETS - 1)];
                p = hot_pc[$urandom_range(0, HOT_PCS - 1)];
            end
            else
            begin
                s = SET_IN_W'($urandom);
                p = {$urandom, $urandom};
            end
            send_access(s, WAY_IN_W'($urandom), p, ($urandom_range(0, 99) < 45));
        end
        wait_for_fills();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_traffic_phase('0);
        run_traffic_phase('1);
        run_traffic_phase(THR_W'(2));
        run_traffic_phase(THR_W'(5));
        run_traffic_phase(THR_RESET);
        run_traffic_phase(THR_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int i;

        // model reset matches the block after its clearing pass
        for (i = 0; i < LINES; i++)
        begin
            line_rrpv[i]   = RRPV_TOP;
            line_sig[i]    = '0;
            line_reused[i] = 1'b0;
        end
        for (i = 0; i < SIG_ENTRIES; i++)
            sig_count[i] = CNT_INIT;
        reuse_thr = THR_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // first word waits out the clearing pass on busy
        test_field_extremes();
        test_set_ageing();
        test_threshold_extremes();
        test_random_traffic();
        wait_for_fills();

        $display("Checked %0d result words: %0d hits, %0d misses, %0d near fills.",
                 checked_words, hit_words, miss_words, near_fills);
        $display("Thresholds swept from 0 to 7 with idle and back-to-back stretches.");
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
